>>> rtl/ncie_pkg.sv
`default_nettype none
package ncie_pkg;

  // bus operation codes
  localparam logic [2:0] BUS_NONE      = 3'd0;
  localparam logic [2:0] BUS_RAM_WR    = 3'd1;
  localparam logic [2:0] BUS_RPORT_WR  = 3'd2;
  localparam logic [2:0] BUS_ROMP_WR   = 3'd3;
  localparam logic [2:0] BUS_STAT_WR   = 3'd4;
  localparam logic [2:0] BUS_RAM_RD    = 3'd5;
  localparam logic [2:0] BUS_ROMP_RD   = 3'd6;
  localparam logic [2:0] BUS_STAT_RD   = 3'd7;

  // opcode groups (high nibble)
  localparam logic [3:0] GRP_NOP = 4'h0;
  localparam logic [3:0] GRP_JCN = 4'h1;
  localparam logic [3:0] GRP_FIM = 4'h2;
  localparam logic [3:0] GRP_FIN = 4'h3;
  localparam logic [3:0] GRP_JUN = 4'h4;
  localparam logic [3:0] GRP_JMS = 4'h5;
  localparam logic [3:0] GRP_INC = 4'h6;
  localparam logic [3:0] GRP_ISZ = 4'h7;
  localparam logic [3:0] GRP_ADD = 4'h8;
  localparam logic [3:0] GRP_SUB = 4'h9;
  localparam logic [3:0] GRP_LD  = 4'hA;
  localparam logic [3:0] GRP_XCH = 4'hB;
  localparam logic [3:0] GRP_BBL = 4'hC;
  localparam logic [3:0] GRP_LDM = 4'hD;
  localparam logic [3:0] GRP_IO  = 4'hE;
  localparam logic [3:0] GRP_ACC = 4'hF;

  // classified instruction passed from front to back
  typedef struct packed {
    logic [3:0] grp;
    logic [3:0] lo;
    logic       ill;
    logic       used;
    logic [7:0] second_byte;
    logic [3:0] read_nibble;
    logic [7:0] indirect_byte;
    logic       test_pin;
  } instr_t;

  typedef struct packed {
    logic [11:0] pc_next;
    logic [3:0]  acc_out;
    logic        carry_out;
    logic [2:0]  bus_op;
    logic [7:0]  bus_addr;
    logic [3:0]  write_data;
    logic [8:0]  indirect_addr;
    logic        used_second_byte;
    logic        illegal_op;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/nibble_cpu_instruction_execute.sv
// path from input item to result item: decode queue register, then execute output register
// throughput: one instruction per cycle while out_tready is high, set by the combinational execute logic
// a result waiting on out_tready stalls the queue, then in_tready
// reset (rst_n low, synchronous): index pairs, stack, level, acc, carry, src,
// bank and stack_mode cleared, both stages emptied
`default_nettype none
module nibble_cpu_instruction_execute #(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode, second_byte, read_nibble, indirect_byte, test_pin
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pc_next, acc_out, carry_out, bus_op, bus_addr, write_data, indirect_addr,
  // used_second_byte, illegal_op
  output logic [47:0]      out_tdata
);
  logic              mode_r;
  logic              q_valid, q_ready;
  ncie_pkg::instr_t  q_data;
  ncie_pkg::result_t res;

  // stack mode register
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  ncie_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_data
  );

  ncie_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .stack_mode(mode_r), .q_valid, .q_ready, .q_data,
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res)
  );

  // pack result fields, first field lowest
  assign out_tdata = {5'b0, res.illegal_op, res.used_second_byte, res.indirect_addr,
                      res.write_data, res.bus_addr, res.bus_op, res.carry_out,
                      res.acc_out, res.pc_next};
endmodule
`default_nettype wire

>>> rtl/ncie_front.sv
`default_nettype none
module ncie_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [31:0]     in_tdata,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output ncie_pkg::instr_t     q_data
);
  logic [7:0]        opc;
  ncie_pkg::instr_t  cls;
  logic              valid_r;
  ncie_pkg::instr_t  data_r;

  // decode opcode into group and flags
  always_comb begin
    opc = in_tdata[7:0];
    cls.grp = opc[7:4];
    cls.lo = opc[3:0];
    cls.ill = ((opc[7:4] == ncie_pkg::GRP_NOP) && (opc[3:0] != 4'h0)) ||
              (opc == 8'hE3) || (opc >= 8'hFE);
    cls.used = !cls.ill && ((opc[7:4] == ncie_pkg::GRP_JCN) ||
               ((opc[7:4] == ncie_pkg::GRP_FIM) && !opc[0]) ||
               (opc[7:4] == ncie_pkg::GRP_JUN) || (opc[7:4] == ncie_pkg::GRP_JMS) ||
               (opc[7:4] == ncie_pkg::GRP_ISZ));
    cls.second_byte = in_tdata[15:8];
    cls.read_nibble = in_tdata[19:16];
    cls.indirect_byte = in_tdata[27:20];
    cls.test_pin = in_tdata[28];
  end

  assign in_tready = !valid_r || q_ready;
  assign q_valid = valid_r;
  assign q_data = data_r;

  // one-entry queue register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= cls;
    end
  end
endmodule
`default_nettype wire

>>> rtl/ncie_back.sv
`default_nettype none
module ncie_back #(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              stack_mode,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire ncie_pkg::instr_t  q_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output ncie_pkg::result_t      res_data
);
  localparam int LW = $clog2(STACK_DEPTH);

  logic [7:0]  pairs_r [8];
  logic [11:0] stack_r [STACK_DEPTH];
  logic [LW-1:0] lvl_r;
  logic [3:0]  acc_r;
  logic        cy_r;
  logic [7:0]  src_r;
  logic [4:0]  bank_r;
  logic        res_valid_r;
  ncie_pkg::result_t res_r;

  logic [LW-1:0] dlast, lvl, lvl_nxt, lvl_up, lvl_dn;
  logic [11:0] pc, pc1, pc2, pc_nxt, ret_pc;
  logic [3:0]  acc_nxt, nib, nib_inc, nib_wr;
  logic        cy_nxt, nib_we, pair_we, push_we, cond, all;
  logic [7:0]  src_nxt, pair_wd, ramaddr, statbase;
  logic [4:0]  bank_nxt;
  logic [2:0]  pr;
  logic [4:0]  sum;
  logic [3:0]  addend;
  logic        do_add, cin;
  logic        fire;
  ncie_pkg::result_t r;

  assign fire = q_valid && q_ready;
  assign q_ready = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res_data = res_r;

  // active depth: four levels or full depth, given as its last level
  assign dlast = stack_mode ? LW'(STACK_DEPTH - 1) : LW'(3);

  function automatic logic [11:0] cond_tgt(input logic [11:0] p, input logic [7:0] a);
    logic [11:0] q;
    begin
      q = (p[7:0] == 8'hFE) ? p + 12'd2 : p;
      cond_tgt = {2'b00, q[9:8], a};
    end
  endfunction

  // execute one classified instruction
  always_comb begin
    // level above the active depth after a mode change folds back by four
    lvl = (lvl_r > dlast) ? lvl_r - LW'(4) : lvl_r;
    lvl_up = (lvl == dlast) ? '0 : lvl + LW'(1);
    lvl_dn = (lvl == '0) ? dlast : lvl - LW'(1);
    pc = stack_r[lvl];
    ret_pc = stack_r[lvl_dn];
    pc1 = pc + 12'd1;
    pc2 = pc + 12'd2;
    pr = q_data.lo[3:1];
    nib = q_data.lo[0] ? pairs_r[pr][3:0] : pairs_r[pr][7:4];
    nib_inc = nib + 4'd1;
    ramaddr = {4'b0, bank_r[4:1]} | src_r;
    statbase = {2'b00, src_r[7:6], src_r[5:4], 2'b00};
    lvl_nxt = lvl;
    pc_nxt = pc1;
    acc_nxt = acc_r;
    cy_nxt = cy_r;
    src_nxt = src_r;
    bank_nxt = bank_r;
    nib_we = 1'b0;
    nib_wr = nib_inc;
    pair_we = 1'b0;
    pair_wd = q_data.second_byte;
    push_we = 1'b0;
    do_add = 1'b0;
    addend = nib;
    cin = cy_r;
    all = 1'b0;
    cond = 1'b0;
    r = '0;
    r.used_second_byte = q_data.used;
    r.illegal_op = q_data.ill;
    if (q_data.ill) begin
      pc_nxt = pc;
    end else begin
      case (q_data.grp)
        ncie_pkg::GRP_JCN: begin
          all = ((acc_r == 4'h0) & q_data.lo[2]) | (cy_r & q_data.lo[1]) |
                (~q_data.test_pin & q_data.lo[0]);
          cond = all ^ q_data.lo[3];
          pc_nxt = cond ? cond_tgt(pc2, q_data.second_byte) : pc2;
        end
        ncie_pkg::GRP_FIM: begin
          if (q_data.lo[0]) begin
            src_nxt = pairs_r[pr];
          end else begin
            pair_we = 1'b1;
            pc_nxt = pc2;
          end
        end
        ncie_pkg::GRP_FIN: begin
          if (q_data.lo[0]) begin
            pc_nxt = (pc1[7:0] == 8'hFF) ? {pc2[11:8], pairs_r[pr]}
                                          : {pc1[11:8], pairs_r[pr]};
          end else begin
            r.indirect_addr = {(pc1[7:0] == 8'hFF), pairs_r[0]};
            pair_we = 1'b1;
            pair_wd = q_data.indirect_byte;
          end
        end
        ncie_pkg::GRP_JUN: pc_nxt = {q_data.lo, q_data.second_byte};
        ncie_pkg::GRP_JMS: begin
          push_we = 1'b1;
          lvl_nxt = lvl_up;
          pc_nxt = {q_data.lo, q_data.second_byte};
        end
        ncie_pkg::GRP_INC: nib_we = 1'b1;
        ncie_pkg::GRP_ISZ: begin
          nib_we = 1'b1;
          pc_nxt = (nib_inc != 4'h0) ? cond_tgt(pc2, q_data.second_byte) : pc2;
        end
        ncie_pkg::GRP_ADD: do_add = 1'b1;
        ncie_pkg::GRP_SUB: begin
          do_add = 1'b1;
          addend = ~nib;
        end
        ncie_pkg::GRP_LD: acc_nxt = nib;
        ncie_pkg::GRP_XCH: begin
          acc_nxt = nib;
          nib_we = 1'b1;
          nib_wr = acc_r;
        end
        ncie_pkg::GRP_BBL: begin
          push_we = 1'b1;
          lvl_nxt = lvl_dn;
          pc_nxt = (lvl_dn == lvl) ? pc1 : ret_pc;
          acc_nxt = q_data.lo;
        end
        ncie_pkg::GRP_LDM: acc_nxt = q_data.lo;
        ncie_pkg::GRP_IO: begin
          case (q_data.lo)
            4'h0: begin
              r.bus_op = ncie_pkg::BUS_RAM_WR; r.bus_addr = ramaddr; r.write_data = acc_r;
            end
            4'h1: begin
              r.bus_op = ncie_pkg::BUS_RPORT_WR; r.bus_addr = {6'b0, src_r[7:6]};
              r.write_data = acc_r;
            end
            4'h2: begin
              r.bus_op = ncie_pkg::BUS_ROMP_WR; r.bus_addr = {4'b0, src_r[7:4]};
              r.write_data = acc_r;
            end
            4'h4, 4'h5, 4'h6, 4'h7: begin
              r.bus_op = ncie_pkg::BUS_STAT_WR; r.bus_addr = statbase | {6'b0, q_data.lo[1:0]};
              r.write_data = acc_r;
            end
            4'h8: begin
              r.bus_op = ncie_pkg::BUS_RAM_RD; r.bus_addr = ramaddr;
              do_add = 1'b1; addend = ~q_data.read_nibble;
            end
            4'h9: begin
              r.bus_op = ncie_pkg::BUS_RAM_RD; r.bus_addr = ramaddr; acc_nxt = q_data.read_nibble;
            end
            4'hA: begin
              r.bus_op = ncie_pkg::BUS_ROMP_RD; r.bus_addr = {4'b0, src_r[7:4]};
              acc_nxt = q_data.read_nibble;
            end
            4'hB: begin
              r.bus_op = ncie_pkg::BUS_RAM_RD; r.bus_addr = ramaddr;
              do_add = 1'b1; addend = q_data.read_nibble;
            end
            default: begin
              r.bus_op = ncie_pkg::BUS_STAT_RD; r.bus_addr = statbase | {6'b0, q_data.lo[1:0]};
              acc_nxt = q_data.read_nibble;
            end
          endcase
        end
        ncie_pkg::GRP_ACC: begin
          case (q_data.lo)
            4'h0: begin acc_nxt = 4'h0; cy_nxt = 1'b0; end
            4'h1: cy_nxt = 1'b0;
            4'h2: begin do_add = 1'b1; addend = 4'h1; cin = 1'b0; end
            4'h3: cy_nxt = ~cy_r;
            4'h4: acc_nxt = ~acc_r;
            4'h5: begin cy_nxt = acc_r[3]; acc_nxt = {acc_r[2:0], cy_r}; end
            4'h6: begin cy_nxt = acc_r[0]; acc_nxt = {cy_r, acc_r[3:1]}; end
            4'h7: begin acc_nxt = {3'b0, cy_r}; cy_nxt = 1'b0; end
            4'h8: begin do_add = 1'b1; addend = 4'hF; cin = 1'b0; end
            4'h9: begin acc_nxt = 4'd9 + {3'b0, cy_r}; cy_nxt = 1'b0; end
            4'hA: cy_nxt = 1'b1;
            4'hB: begin
              if (acc_r > 4'd9 || cy_r) begin
                acc_nxt = acc_r + 4'd6;
                if (acc_r > 4'd9) cy_nxt = 1'b1;
              end
            end
            4'hC: begin
              if (acc_r == 4'd4) acc_nxt = 4'd3;
              else if (acc_r == 4'd8) acc_nxt = 4'd4;
              else if (acc_r > 4'd2) acc_nxt = 4'hF;
            end
            default: bank_nxt = (acc_r == 4'h0) ? 5'd1 : {acc_r, 1'b0};
          endcase
        end
        default: ;
      endcase
    end
    // shared nibble adder
    sum = {1'b0, acc_r} + {1'b0, addend} + {4'b0, cin};
    if (do_add) begin
      acc_nxt = sum[3:0];
      cy_nxt = sum[4];
    end
    r.pc_next = pc_nxt;
    r.acc_out = acc_nxt;
    r.carry_out = cy_nxt;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) pairs_r[i] <= 8'h00;
      for (int i = 0; i < STACK_DEPTH; i++) stack_r[i] <= 12'h000;
      lvl_r <= '0;
      acc_r <= 4'h0;
      cy_r <= 1'b0;
      src_r <= 8'h00;
      bank_r <= 5'h00;
    end else if (fire) begin
      lvl_r <= lvl_nxt;
      if (!q_data.ill) begin
        if (push_we) stack_r[lvl] <= (q_data.grp == ncie_pkg::GRP_JMS) ? pc2 : pc1;
        stack_r[lvl_nxt] <= pc_nxt;
        acc_r <= acc_nxt;
        cy_r <= cy_nxt;
        src_r <= src_nxt;
        bank_r <= bank_nxt;
        if (pair_we) pairs_r[pr] <= pair_wd;
        else if (nib_we) begin
          if (q_data.lo[0]) pairs_r[pr][3:0] <= nib_wr;
          else pairs_r[pr][7:4] <= nib_wr;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (q_ready) begin
      res_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= r;
  end
endmodule
`default_nettype wire
